// ===== sv/bqlp_pkg.sv =====
package bqlp_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB1 = 3'd0,
    REG_FB2 = 3'd1,
    REG_FF0 = 3'd2,
    REG_FF1 = 3'd3,
    REG_FF2 = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FB2,
    S_FF1,
    S_MID,
    S_FZ,
    S_LAST,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FB1,
    MUL_FB2,
    MUL_FF1,
    MUL_FF2,
    MUL_FZ
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB,
    ACC_ADD,
    ACC_LOAD_PROD
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     m_load;
    logic     out_load;
    logic     in_ready;
  } ctrl_t;

endpackage

// ===== sv/biquad_lowpass_filter.sv =====
// an accepted input runs the six sequencer steps S_FB2 to S_OUT, and S_OUT
// loads the registered result and out_valid; the next sample is accepted only in
// the idle state after them, and S_OUT waits while a pending result is not taken
// the single shared multiplier forms the five products in sequence, and the
// accumulator adds the last one in the cycle after it is formed
// synchronous active-low reset clears the delays and the output valid flag and
// loads the coefficients for pass-through (forward_zero = 1.0, others 0)
module biquad_lowpass_filter import bqlp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped
);

  localparam int D  = SAMPLE_BITS + 8;
  localparam int F  = COEF_BITS - 4;
  localparam int PW = D + COEF_BITS;
  localparam int AW = PW + 2;

  state_t state_r, state_nxt;
  ctrl_t  ctrl;

  logic signed [COEF_BITS-1:0] fb1_r, fb2_r, ff0_r, ff1_r, ff2_r;
  logic signed [D-1:0]         d1_r, d2_r, m_r;
  logic signed [PW-1:0]        prod_r;
  logic signed [AW-1:0]        acc_r;
  logic                        clip_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                        out_clipped_r;

  logic signed [COEF_BITS-1:0] mul_a;
  logic signed [D-1:0]         mul_b;
  logic signed [PW-1:0]        prod_nxt;
  logic signed [AW-1:0]        acc_nxt, acc_sh, acc_x, acc_half, prod_ext;
  logic [AW-D:0]               m_hi;
  logic [AW-SAMPLE_BITS:0]     y_hi;
  logic                        m_ovf, y_ovf;
  logic signed [D-1:0]         m_sat;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_FB2;
      S_FB2:  state_nxt = S_FF1;
      S_FF1:  state_nxt = S_MID;
      S_MID:  state_nxt = S_FZ;
      S_FZ:   state_nxt = S_LAST;
      S_LAST: state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, m_load: 1'b0,
             out_load: 1'b0, in_ready: 1'b0};
    case (state_r)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (in_valid) begin
          ctrl.mul_sel = MUL_FB1;
          ctrl.acc_op  = ACC_LOAD_X;
        end
      end
      S_FB2: begin
        ctrl.mul_sel = MUL_FB2;
        ctrl.acc_op  = ACC_SUB;
      end
      S_FF1: begin
        ctrl.mul_sel = MUL_FF1;
        ctrl.acc_op  = ACC_SUB;
      end
      S_MID: begin
        ctrl.mul_sel = MUL_FF2;
        ctrl.acc_op  = ACC_LOAD_PROD;
        ctrl.m_load  = 1'b1;
      end
      S_FZ: begin
        ctrl.mul_sel = MUL_FZ;
        ctrl.acc_op  = ACC_ADD;
      end
      S_LAST: ctrl.acc_op = ACC_ADD;
      S_OUT:  ctrl.out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // shared multiplier
  always_comb begin
    mul_a = fb1_r;
    mul_b = d1_r;
    case (ctrl.mul_sel)
      MUL_FB1: begin mul_a = fb1_r; mul_b = d1_r; end
      MUL_FB2: begin mul_a = fb2_r; mul_b = d2_r; end
      MUL_FF1: begin mul_a = ff1_r; mul_b = d1_r; end
      MUL_FF2: begin mul_a = ff2_r; mul_b = d2_r; end
      MUL_FZ:  begin mul_a = ff0_r; mul_b = m_r; end
      default: ;
    endcase
  end

  assign prod_nxt = (ctrl.mul_sel == MUL_NONE) ? prod_r : mul_a * mul_b;

  // accumulator, rounding constant folded in at load
  assign acc_half = {{(AW-1){1'b0}}, 1'b1} << (F - 1);
  assign acc_x    = ({{(AW-SAMPLE_BITS){in_sample_in[SAMPLE_BITS-1]}}, in_sample_in} << F)
                    + acc_half;
  assign prod_ext = {{2{prod_r[PW-1]}}, prod_r};

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD_X:    acc_nxt = acc_x;
      ACC_SUB:       acc_nxt = acc_r - prod_ext;
      ACC_ADD:       acc_nxt = acc_r + prod_ext;
      ACC_LOAD_PROD: acc_nxt = acc_half + prod_ext;
      default:       acc_nxt = acc_r;
    endcase
  end

  // round and saturate
  assign acc_sh = acc_r >>> F;
  assign m_hi   = acc_sh[AW-1:D-1];
  assign m_ovf  = !((&m_hi) || !(|m_hi));
  assign m_sat  = m_ovf ? {acc_sh[AW-1], {(D-1){~acc_sh[AW-1]}}} : acc_sh[D-1:0];
  assign y_hi   = acc_sh[AW-1:SAMPLE_BITS-1];
  assign y_ovf  = !((&y_hi) || !(|y_hi));
  assign y_sat  = y_ovf ? {acc_sh[AW-1], {(SAMPLE_BITS-1){~acc_sh[AW-1]}}}
                        : acc_sh[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fb1_r       <= '0;
      fb2_r       <= '0;
      ff0_r       <= {{(COEF_BITS-1){1'b0}}, 1'b1} << F;
      ff1_r       <= '0;
      ff2_r       <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FB1: fb1_r <= cfg_data;
          REG_FB2: fb2_r <= cfg_data;
          REG_FF0: ff0_r <= cfg_data;
          REG_FF1: ff1_r <= cfg_data;
          REG_FF2: ff2_r <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
        d2_r        <= d1_r;
        d1_r        <= m_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctrl.m_load) begin
      m_r    <= m_sat;
      clip_r <= m_ovf;
    end
    if (ctrl.out_load) begin
      out_sample_r  <= y_sat;
      out_clipped_r <= clip_r | y_ovf;
    end
  end

  assign in_ready       = ctrl.in_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_FB2)
    else $error("accepted transaction did not start the sequence");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT)
    else $error("output raised outside the output step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid && !out_ready |=> state_r == S_OUT && out_valid)
    else $error("pending result dropped");

endmodule

// ===== verif/tb_biquad_lowpass_filter.sv =====
`timescale 1ns / 100ps

module tb_biquad_lowpass_filter import bqlp_pkg::*;;

  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int COEF_BITS    = COEF_BITS_DEF;
  localparam int FRAC         = COEF_BITS - 4;
  localparam int DLY_BITS     = SAMPLE_BITS + 8;
  localparam int ACC_W        = DLY_BITS + COEF_BITS + 4;
  localparam int NUM_REGS     = int'(REG_FF2) + 1;
  localparam int RAND_PHASES  = 8;
  localparam int LAT_CYCLES   = 12;
  localparam int LIMIT_CYCLES = 400000;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [DLY_BITS-1:0] DLY_TOP = {1'b0, {(DLY_BITS-1){1'b1}}};
  localparam logic signed [DLY_BITS-1:0] DLY_BOT = {1'b1, {(DLY_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum int {
    KIND_LOWPASS,
    KIND_MODERATE,
    KIND_WILD,
    KIND_CORNERS
  } coef_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
  } filt_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [COEF_BITS-1:0]          cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          out_clipped;

  logic signed [COEF_BITS-1:0]   coef [NUM_REGS];
  logic [COEF_BITS-1:0]          next_coef [1 << CFG_IDX_W];
  int                            lp_coef [NUM_REGS];
  logic signed [DLY_BITS-1:0]    delay_one_q = '0;
  logic signed [DLY_BITS-1:0]    delay_two_q = '0;

  logic [SAMPLE_BITS-1:0]        sample_q [$];
  filt_result_t                  expected_out_q [$];
  filt_result_t                  want;
  bit                            quiet = 1'b0;
  bit                            long_hold_done = 1'b0;
  int                            send_gap = 0;
  int                            recv_hold = 0;
  int                            n_results = 0;
  int                            n_errors = 0;
  int unsigned                   cycle_cnt = 0;

  biquad_lowpass_filter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic filt_result_t filter_step(input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [ACC_W-1:0] xe, d1, d2, acc, m;
    logic signed [ACC_W-1:0] c_fb1, c_fb2, c_ff0, c_ff1, c_ff2;
    filt_result_t r;
    xe = x;
    d1 = delay_one_q;
    d2 = delay_two_q;
    c_fb1 = coef[REG_FB1];
    c_fb2 = coef[REG_FB2];
    c_ff0 = coef[REG_FF0];
    c_ff1 = coef[REG_FF1];
    c_ff2 = coef[REG_FF2];
    r.clipped = 1'b0;
    // feedback sum, rounded half up, clamped to the delay range
    acc = ((xe <<< FRAC) - c_fb1 * d1 - c_fb2 * d2 + HALF) >>> FRAC;
    if (acc > DLY_TOP) begin
      acc = DLY_TOP;
      r.clipped = 1'b1;
    end else if (acc < DLY_BOT) begin
      acc = DLY_BOT;
      r.clipped = 1'b1;
    end
    m = acc;
    acc = (c_ff0 * m + c_ff1 * d1 + c_ff2 * d2 + HALF) >>> FRAC;
    if (acc > SMP_TOP) begin
      acc = SMP_TOP;
      r.clipped = 1'b1;
    end else if (acc < SMP_BOT) begin
      acc = SMP_BOT;
      r.clipped = 1'b1;
    end
    r.sample = acc[SAMPLE_BITS-1:0];
    delay_two_q = delay_one_q;
    delay_one_q = m[DLY_BITS-1:0];
    return r;
  endfunction

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || expected_out_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  // writes all coefficients, plus the unused indexes when junk is set
  task automatic apply_coefs(input bit junk);
    for (int r = NUM_REGS; r < (1 << CFG_IDX_W); r++) next_coef[r] = $urandom;
    for (int r = 0; r < (1 << CFG_IDX_W); r++) begin
      if (r < NUM_REGS || junk) begin
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_W'(r);
        cfg_data <= next_coef[r];
        if (r < NUM_REGS) coef[r] = next_coef[r];
      end
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_out_q.push_back(filter_step(in_sample_in));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (sample_q.size() != 0) begin
          in_valid <= 1'b1;
          in_sample_in <= sample_q.pop_front();
          send_gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_out_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected transaction: sample_out %0d clipped %0b",
                     out_sample_out, out_clipped);
        end else begin
          want = expected_out_q.pop_front();
          if (out_sample_out !== want.sample || out_clipped !== want.clipped) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                       want.sample, out_sample_out, want.clipped, out_clipped);
          end
        end
      end
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else if (n_results >= 120 && !long_hold_done) begin
        // long back-pressure so the input side stalls
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        recv_hold = 400;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        recv_hold = idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL biquad_lowpass_filter");
      $finish;
    end
  end

  initial begin
    coef_kind_t             kind;
    int                     n_items;
    int                     sel;
    logic [SAMPLE_BITS-1:0] s;

    for (int r = 0; r < NUM_REGS; r++) coef[r] = '0;
    coef[REG_FF0] = 1 << FRAC;
    // roughly fs/8 low-pass, q of 0.707
    lp_coef[REG_FB1] = -253083632;
    lp_coef[REG_FB2] = 89478485;
    lp_coef[REG_FF0] = 26207354;
    lp_coef[REG_FF1] = 52414708;
    lp_coef[REG_FF2] = 26207354;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // pass-through after reset
    sample_q.push_back('0);
    sample_q.push_back(SMP_TOP);
    sample_q.push_back(SMP_BOT);
    sample_q.push_back(SAMPLE_BITS'(1));
    sample_q.push_back(SAMPLE_BITS'(-1));
    sample_q.push_back(24'h555555);
    sample_q.push_back(24'hAAAAAA);
    sample_q.push_back(SMP_TOP);

    // gain of one half: rounding ties go toward plus infinity
    wait_idle();
    for (int r = 0; r < NUM_REGS; r++) next_coef[r] = '0;
    next_coef[REG_FF0] = 1 << (FRAC - 1);
    apply_coefs(1'b1);
    sample_q.push_back(SAMPLE_BITS'(1));
    sample_q.push_back(SAMPLE_BITS'(-1));
    sample_q.push_back(SAMPLE_BITS'(3));
    sample_q.push_back(SAMPLE_BITS'(-3));

    // all coefficients at the positive extreme, delays and output clamp
    wait_idle();
    for (int r = 0; r < NUM_REGS; r++) next_coef[r] = 32'h7FFF_FFFF;
    apply_coefs(1'b0);
    sample_q.push_back(SMP_TOP);
    sample_q.push_back(SMP_TOP);
    sample_q.push_back(SMP_TOP);
    sample_q.push_back(SMP_BOT);
    sample_q.push_back(SMP_BOT);
    sample_q.push_back('0);
    sample_q.push_back(SAMPLE_BITS'(1));

    // all coefficients at the negative extreme
    wait_idle();
    for (int r = 0; r < NUM_REGS; r++) next_coef[r] = 32'h8000_0000;
    apply_coefs(1'b0);
    sample_q.push_back(SMP_BOT);
    sample_q.push_back(SMP_TOP);
    sample_q.push_back(SMP_TOP);
    sample_q.push_back('0);
    sample_q.push_back(SAMPLE_BITS'(-1));
    sample_q.push_back(SMP_TOP);

    for (int p = 0; p < RAND_PHASES; p++) begin
      kind = coef_kind_t'(p % 4);
      for (int r = 0; r < NUM_REGS; r++) begin
        case (kind)
          KIND_LOWPASS:  next_coef[r] = lp_coef[r] + $urandom_range(0, 1023) - 512;
          KIND_MODERATE: next_coef[r] = $urandom_range(0, 1 << 29) - (1 << 28);
          KIND_WILD:     next_coef[r] = $urandom;
          default: begin
            case ($urandom_range(0, 4))
              0:       next_coef[r] = 32'h7FFF_FFFF;
              1:       next_coef[r] = 32'h8000_0000;
              2:       next_coef[r] = '0;
              3:       next_coef[r] = 1 << FRAC;
              default: next_coef[r] = -(1 << FRAC);
            endcase
          end
        endcase
      end
      wait_idle();
      apply_coefs($urandom_range(0, 3) == 0);
      quiet = (p % 3 == 2);
      n_items = $urandom_range(70, 86);
      repeat (n_items) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) s = SAMPLE_BITS'($urandom);
        else if (sel < 8) s = SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
        else if (sel == 8) s = $urandom_range(0, 1) ? SMP_TOP : SMP_BOT;
        else s = '0;
        sample_q.push_back(s);
      end
    end

    wait_idle();
    if (n_errors == 0 && expected_out_q.size() == 0) begin
      $display("PASS biquad_lowpass_filter");
    end else begin
      $display("FAIL biquad_lowpass_filter");
    end
    $finish;
  end

endmodule

// ===== biquad_lowpass_filter.f =====
sv/bqlp_pkg.sv
sv/biquad_lowpass_filter.sv
verif/tb_biquad_lowpass_filter.sv
